FILE: rtl/core/mmd_pkg.sv
// ---------------------------------------------------------------------------
// mmd_pkg: shared types and constants of the minimum Mahalanobis distance unit
// Holds table sizes, the command codes and the controller-to-datapath bundle.
// ---------------------------------------------------------------------------
`default_nettype none
package mmd_pkg;
    localparam int MAX_DIM        = 16;
    localparam int MAX_COMPONENTS = 8;
    localparam int DIM_W          = $clog2(MAX_DIM);
    localparam int COMP_W         = $clog2(MAX_COMPONENTS);
    localparam int MEAN_AW        = COMP_W + DIM_W;
    localparam int MAT_AW         = COMP_W + 2 * DIM_W;
    localparam int VAL_W          = 32;
    localparam int OUT_W          = 48;
    localparam int PROD_W         = 49;
    localparam int T_W            = PROD_W + DIM_W;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam logic [1:0] CMD_MEAN   = 2'd0;
    localparam logic [1:0] CMD_MATRIX = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic CFG_DIM   = 1'b0;
    localparam logic CFG_NCOMP = 1'b1;

    typedef struct packed {
        logic              wr_mean;
        logic              wr_mat;
        logic              wr_sample;
        logic              init;
        logic              mac_rd;
        logic              mac_mul;
        logic              mac_acc;
        logic              sq;
        logic              add;
        logic              cmp;
        logic [COMP_W-1:0] comp;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
    } t_ctrl;
endpackage
`default_nettype wire

FILE: rtl/core/min_mahalanobis_distance.sv
// ---------------------------------------------------------------------------
// min_mahalanobis_distance: smallest squared Mahalanobis distance to a set
// of Gaussian components, one result per completed sample.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// item      in         i_start & !o_busy    i_command i_component i_row i_col i_value
// result    out        o_done (one cycle)   o_min_distance
// config    in         i_cfg_we             i_cfg_index i_cfg_data
//
// Load items and sample elements that do not complete a sample leave the unit idle.
// The last sample element starts the computation, run component by component
// on the single shared multiply-accumulate unit and followed by the result
// strobe; o_busy is high throughout.
// Reset is synchronous; tables and sample buffer are not cleared.
// The result is shown for one cycle and cannot be held off.
`default_nettype none
module min_mahalanobis_distance import mmd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [1:0]        i_command,
    input  wire logic [2:0]        i_component,
    input  wire logic [3:0]        i_row,
    input  wire logic [3:0]        i_col,
    input  wire logic signed [31:0] i_value,
    output logic                   o_done,
    output logic [47:0]            o_min_distance,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [4:0]        i_cfg_data
);
    t_ctrl ctrl;

    mmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_command   (i_command),
        .i_row       (i_row),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctrl      (ctrl),
        .o_busy      (o_busy),
        .o_done      (o_done)
    );

    mmd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_component    (i_component),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_value        (i_value),
        .o_min_distance (o_min_distance)
    );
endmodule
`default_nettype wire

FILE: rtl/core/mmd_datapath.sv
// ---------------------------------------------------------------------------
// mmd_datapath: tables, multiply-accumulate unit and minimum tracking
// Stores means, transform matrices and the sample; runs one MAC step per
// command from the controller and keeps the smallest distance.
// ---------------------------------------------------------------------------
`default_nettype none
module mmd_datapath import mmd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctrl             i_ctrl,
    input  wire logic [COMP_W-1:0] i_component,
    input  wire logic [DIM_W-1:0]  i_row,
    input  wire logic [DIM_W-1:0]  i_col,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic [OUT_W-1:0]       o_min_distance
);
    logic signed [VAL_W-1:0] r_mean_mem [MAX_COMPONENTS*MAX_DIM];
    logic signed [VAL_W-1:0] r_mat_mem  [MAX_COMPONENTS*MAX_DIM*MAX_DIM];
    logic signed [VAL_W-1:0] r_sample   [MAX_DIM];

    logic signed [VAL_W-1:0]  r_mean_q, r_mat_q, r_samp_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [T_W-1:0]    r_t;
    logic [OUT_W-1:0]         r_sq, r_acc, r_best;
    logic                     r_big, r_sat;

    logic signed [VAL_W:0]     diff;
    logic signed [2*VAL_W:0]   prod_full;
    logic [T_W-1:0]            t_mag;
    logic [2*VAL_W-1:0]        sq_full;
    logic [OUT_W:0]            sum;
    logic [OUT_W-1:0]          comp_dist;

    always_comb begin
        diff      = {r_samp_q[VAL_W-1], r_samp_q} - {r_mean_q[VAL_W-1], r_mean_q};
        prod_full = diff * r_mat_q;
        t_mag     = r_t[T_W-1] ? T_W'(-r_t) : T_W'(r_t);
        sq_full   = t_mag[VAL_W-1:0] * t_mag[VAL_W-1:0];
        sum       = {1'b0, r_acc} + {1'b0, r_sq};
        comp_dist = r_sat ? OUT_MAX : r_acc;
    end

    // Table writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_mean) begin
            r_mean_mem[{i_component, i_row}] <= i_value;
        end
        if (i_ctrl.mac_rd) begin
            r_mean_q <= r_mean_mem[{i_ctrl.comp, i_ctrl.row}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_mat) begin
            r_mat_mem[{i_component, i_row, i_col}] <= i_value;
        end
        if (i_ctrl.mac_rd) begin
            r_mat_q <= r_mat_mem[{i_ctrl.comp, i_ctrl.row, i_ctrl.col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_sample) begin
            r_sample[i_row] <= i_value;
        end
        if (i_ctrl.mac_rd) begin
            r_samp_q <= r_sample[i_ctrl.row];
        end
    end

    // Product is floored to Q16.16 by the arithmetic shift.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mac_mul) begin
            r_prod <= PROD_W'(prod_full >>> 16);
        end
        if (i_ctrl.init || i_ctrl.add) begin
            r_t <= '0;
        end else if (i_ctrl.mac_acc) begin
            r_t <= r_t + T_W'(r_prod);
        end
        if (i_ctrl.sq) begin
            r_sq  <= sq_full[2*VAL_W-1:16];
            r_big <= |t_mag[T_W-1:VAL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_sat  <= 1'b0;
            r_best <= OUT_MAX;
        end else if (i_ctrl.init) begin
            r_acc  <= '0;
            r_sat  <= 1'b0;
            r_best <= OUT_MAX;
        end else if (i_ctrl.add) begin
            if (r_big || sum[OUT_W]) begin
                r_sat <= 1'b1;
            end else begin
                r_acc <= sum[OUT_W-1:0];
            end
        end else if (i_ctrl.cmp) begin
            if (comp_dist < r_best) begin
                r_best <= comp_dist;
            end
            r_acc <= '0;
            r_sat <= 1'b0;
        end
    end

    assign o_min_distance = r_best;
endmodule
`default_nettype wire

FILE: rtl/core/mmd_ctrl.sv
// ---------------------------------------------------------------------------
// mmd_ctrl: sequencer of the minimum Mahalanobis distance unit
// Decodes items, holds the configuration registers and walks the
// component, column and row loops of the distance computation.
// ---------------------------------------------------------------------------
`default_nettype none
module mmd_ctrl import mmd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_command,
    input  wire logic [DIM_W-1:0] i_row,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [4:0]       i_cfg_data,
    output t_ctrl                 o_ctrl,
    output logic                  o_busy,
    output logic                  o_done
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_ACC  = 8'b0000_1000,
        S_SQ   = 8'b0001_0000,
        S_ADD  = 8'b0010_0000,
        S_CMP  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [4:0]        r_dim;
    logic [3:0]        r_ncomp;
    logic [COMP_W-1:0] r_c, n_c;
    logic [DIM_W-1:0]  r_r, n_r, r_col, n_col;
    logic [DIM_W:0]    dim;
    logic [COMP_W:0]   ncomp;
    logic [DIM_W-1:0]  last_dim;
    logic [COMP_W-1:0] last_comp;
    logic              accept;

    always_comb begin
        if (r_dim == '0) begin
            dim = (DIM_W+1)'(1);
        end else if (r_dim > 5'(MAX_DIM)) begin
            dim = (DIM_W+1)'(MAX_DIM);
        end else begin
            dim = (DIM_W+1)'(r_dim);
        end
        if (r_ncomp == '0) begin
            ncomp = (COMP_W+1)'(1);
        end else if (r_ncomp > 4'(MAX_COMPONENTS)) begin
            ncomp = (COMP_W+1)'(MAX_COMPONENTS);
        end else begin
            ncomp = (COMP_W+1)'(r_ncomp);
        end
        last_dim  = DIM_W'(dim - 1'b1);
        last_comp = COMP_W'(ncomp - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= 5'(MAX_DIM);
            r_ncomp <= 4'(MAX_COMPONENTS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIM:   r_dim   <= i_cfg_data;
                CFG_NCOMP: r_ncomp <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_r     = r_r;
        n_col   = r_col;
        o_ctrl  = '0;
        o_ctrl.comp = r_c;
        o_ctrl.row  = r_r;
        o_ctrl.col  = r_col;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_ctrl.wr_mean = (i_command == CMD_MEAN);
                    o_ctrl.wr_mat  = (i_command == CMD_MATRIX);
                    if (i_command == CMD_SAMPLE && {1'b0, i_row} < dim) begin
                        o_ctrl.wr_sample = 1'b1;
                        if (i_row == last_dim) begin
                            o_ctrl.init = 1'b1;
                            n_c     = '0;
                            n_r     = '0;
                            n_col   = '0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                o_ctrl.mac_rd = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_ctrl.mac_mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_ctrl.mac_acc = 1'b1;
                if (r_r == last_dim) begin
                    n_r     = '0;
                    n_state = S_SQ;
                end else begin
                    n_r     = r_r + 1'b1;
                    n_state = S_RD;
                end
            end
            S_SQ: begin
                o_ctrl.sq = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_ctrl.add = 1'b1;
                if (r_col == last_dim) begin
                    n_col   = '0;
                    n_state = S_CMP;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_state = S_RD;
                end
            end
            S_CMP: begin
                o_ctrl.cmp = 1'b1;
                if (r_c == last_comp) begin
                    n_state = S_DONE;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_c     <= '0;
            r_r     <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_r     <= n_r;
            r_col   <= n_col;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
endmodule
`default_nettype wire

FILE: rtl/core/mmd_checker.sv
// ---------------------------------------------------------------------------
// mmd_checker: port-level checks of the minimum Mahalanobis distance unit
// Watches the item and result handshakes over time.
// ---------------------------------------------------------------------------
`default_nettype none
module mmd_checker import mmd_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic [1:0]  i_command,
    input wire logic        o_done
);
    // A result only ends a computation.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy)) else $error("result without computation");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !o_busy) else $error("result strobe too long");

    // Table loads never start a computation.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_command != CMD_SAMPLE) |=> !o_busy && !o_done)
        else $error("load item started work");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_busy && !o_done) else $error("not idle after reset");
endmodule

bind min_mahalanobis_distance mmd_checker u_mmd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .o_busy    (o_busy),
    .i_command (i_command),
    .o_done    (o_done)
);
`default_nettype wire

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the minimum Mahalanobis distance unit
// Loads mean and transform tables, streams sample items under several
// register settings and sender gap rates, and compares every result strobe
// against a bit-exact prediction held in a small scoreboard.
// ---------------------------------------------------------------------------
`default_nettype none

class mmd_scoreboard;
    longint        mean_t [mmd_pkg::MAX_COMPONENTS][mmd_pkg::MAX_DIM];
    longint        mat_t  [mmd_pkg::MAX_COMPONENTS][mmd_pkg::MAX_DIM][mmd_pkg::MAX_DIM];
    longint        smp_t  [mmd_pkg::MAX_DIM];
    bit [4:0]      dim_reg;
    bit [3:0]      ncomp_reg;
    bit [47:0]     dist_q[$];
    int            errors;

    function new();
        dim_reg   = 5'd16;
        ncomp_reg = 4'd8;
        errors    = 0;
    endfunction

    function int pending();
        return dist_q.size();
    endfunction

    function int dims_used();
        if (dim_reg < 1) return 1;
        return (dim_reg > mmd_pkg::MAX_DIM) ? mmd_pkg::MAX_DIM : int'(dim_reg);
    endfunction

    function int comps_used();
        if (ncomp_reg < 1) return 1;
        return (ncomp_reg > mmd_pkg::MAX_COMPONENTS) ? mmd_pkg::MAX_COMPONENTS
                                                     : int'(ncomp_reg);
    endfunction

    function void set_reg(logic idx, logic [4:0] data);
        if (idx == mmd_pkg::CFG_DIM) dim_reg = data;
        else ncomp_reg = data[3:0];
    endfunction

    // Product floored to Q16.16 like the arithmetic shift: a negative magnitude is rounded up.
    function longint scaled_product(longint d, longint m);
        longint unsigned p;
        p = longint'(d < 0 ? -d : d) * longint'(m < 0 ? -m : m);
        if ((d < 0) != (m < 0)) return -longint'((p + 64'hFFFF) >> 16);
        return longint'(p >> 16);
    endfunction

    function bit [47:0] component_distance(int c, int dims);
        longint unsigned acc;
        longint          t;
        longint unsigned a;
        acc = 0;
        for (int col = 0; col < dims; col++) begin
            t = 0;
            for (int r = 0; r < dims; r++)
                t += scaled_product(smp_t[r] - mean_t[c][r], mat_t[c][r][col]);
            a = (t < 0) ? -t : t;
            if (a >= 64'h1_0000_0000) return mmd_pkg::OUT_MAX;
            acc += (a * a) >> 16;
            if (acc > 64'hFFFF_FFFF_FFFF) return mmd_pkg::OUT_MAX;
        end
        return acc[47:0];
    endfunction

    function void note_item(logic [1:0] cmd, logic [2:0] comp, logic [3:0] row,
                            logic [3:0] col, logic signed [31:0] val);
        bit [47:0] best;
        bit [47:0] d;
        int        dims;
        case (cmd)
            mmd_pkg::CMD_MEAN:   mean_t[comp][row] = longint'(val);
            mmd_pkg::CMD_MATRIX: mat_t[comp][row][col] = longint'(val);
            mmd_pkg::CMD_SAMPLE: begin
                dims = dims_used();
                if (row < dims) begin
                    smp_t[row] = longint'(val);
                    if (row == dims - 1) begin
                        best = mmd_pkg::OUT_MAX;
                        for (int c = 0; c < comps_used(); c++) begin
                            d = component_distance(c, dims);
                            if (d < best) best = d;
                        end
                        dist_q.push_back(best);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check(logic [47:0] got);
        bit [47:0] want;
        if (dist_q.size() == 0) begin
            report($sformatf("unexpected result min_distance=%h", got));
        end else begin
            want = dist_q.pop_front();
            if (got !== want)
                report($sformatf("min_distance got %h want %h", got, want));
        end
    endtask
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mmd_pkg::*;

    localparam int STALL_LIMIT = 30000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [1:0]        i_command;
    logic [2:0]        i_component;
    logic [3:0]        i_row;
    logic [3:0]        i_col;
    logic signed [31:0] i_value;
    logic              o_done;
    logic [47:0]       o_min_distance;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [4:0]        i_cfg_data;

    mmd_scoreboard sb;
    int            gap_pct;
    int            stall_cnt;
    // Written flags keep every sample from reading a table entry never loaded.
    bit            mean_ok [MAX_COMPONENTS][MAX_DIM];
    bit            mat_ok  [MAX_COMPONENTS][MAX_DIM][MAX_DIM];
    bit            smp_ok  [MAX_DIM];

    min_mahalanobis_distance dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check(o_min_distance);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || i_cfg_we) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic logic signed [31:0] rand_value();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $signed($urandom_range(0, 131071)) - 32'sd65536;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance, or later after a random gap.
    task automatic send(logic [1:0] cmd, logic [2:0] comp, logic [3:0] row,
                        logic [3:0] col, logic signed [31:0] val);
        i_start     = 1'b1;
        i_command   = cmd;
        i_component = comp;
        i_row       = row;
        i_col       = col;
        i_value     = val;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        sb.note_item(cmd, comp, row, col, val);
        if (cmd == CMD_MEAN) mean_ok[comp][row] = 1'b1;
        if (cmd == CMD_MATRIX) mat_ok[comp][row][col] = 1'b1;
        if (cmd == CMD_SAMPLE) smp_ok[row] = 1'b1;
        @(negedge i_clk);
        i_start = 1'b0;
        if ($urandom_range(0, 99) < gap_pct) repeat ($urandom_range(1, 4)) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (sb.pending() > 0 || o_busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Loads every entry the current setting will read that is still unwritten.
    task automatic fill_missing();
        int dims;
        dims = sb.dims_used();
        for (int c = 0; c < sb.comps_used(); c++)
            for (int r = 0; r < dims; r++) begin
                if (!mean_ok[c][r]) send(CMD_MEAN, 3'(c), 4'(r), 4'd0, rand_value());
                for (int k = 0; k < dims; k++)
                    if (!mat_ok[c][r][k])
                        send(CMD_MATRIX, 3'(c), 4'(r), 4'(k), rand_value());
            end
        for (int r = 0; r < dims - 1; r++)
            if (!smp_ok[r]) send(CMD_SAMPLE, 3'd0, 4'(r), 4'd0, rand_value());
    endtask

    task automatic run_phase(logic [4:0] dim_val, logic [4:0] comp_val, int gap,
                             int count, bit hold_off);
        int dims;
        int pos;
        int pick;
        wait_idle();
        write_reg(CFG_DIM, dim_val);
        write_reg(CFG_NCOMP, comp_val);
        gap_pct = gap;
        fill_missing();
        dims = sb.dims_used();
        pos  = 0;
        for (int n = 0; n < count; n++) begin
            if (hold_off && n == count / 2) wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send(CMD_MEAN, 3'($urandom), 4'($urandom), 4'($urandom), rand_value());
            end else if (pick < 24) begin
                send(CMD_MATRIX, 3'($urandom), 4'($urandom), 4'($urandom), rand_value());
            end else if (pick < 28) begin
                send(CMD_UNUSED, 3'($urandom), 4'($urandom), 4'($urandom),
                     32'($urandom));
            end else if (pick < 32 && dims < MAX_DIM) begin
                send(CMD_SAMPLE, 3'($urandom), 4'($urandom_range(dims, 15)),
                     4'($urandom), 32'($urandom));
            end else begin
                // A broken sequence jumps to a random position now and then.
                if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, dims - 1);
                send(CMD_SAMPLE, 3'($urandom), 4'(pos), 4'($urandom), rand_value());
                pos = (pos + 1) % dims;
            end
        end
    endtask

    initial begin
        sb          = new();
        gap_pct     = 0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_command   = CMD_MEAN;
        i_component = '0;
        i_row       = '0;
        i_col       = '0;
        i_value     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_DIM;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: extremes, every command, ignored items, saturation.
        write_reg(CFG_DIM, 5'd4);
        write_reg(CFG_NCOMP, 5'd2);
        fill_missing();
        send(CMD_MEAN, 3'd7, 4'd15, 4'd0, 32'sh7FFF_FFFF);
        send(CMD_MATRIX, 3'd7, 4'd15, 4'd15, 32'sh8000_0000);
        send(CMD_UNUSED, 3'd7, 4'd15, 4'd15, 32'shFFFF_FFFF);
        send(CMD_SAMPLE, 3'd0, 4'd9, 4'd0, 32'sh0001_0000);
        send(CMD_SAMPLE, 3'd0, 4'd15, 4'd15, 32'sh0);
        send(CMD_SAMPLE, 3'd0, 4'd0, 4'd0, 32'sh8000_0000);
        send(CMD_SAMPLE, 3'd0, 4'd1, 4'd0, 32'sh7FFF_FFFF);
        send(CMD_SAMPLE, 3'd0, 4'd2, 4'd0, 32'sh8000_0000);
        send(CMD_SAMPLE, 3'd0, 4'd3, 4'd0, 32'sh7FFF_FFFF);
        send(CMD_MATRIX, 3'd0, 4'd0, 4'd0, 32'sh0);
        send(CMD_MEAN, 3'd0, 4'd0, 4'd0, 32'sh0);
        for (int r = 0; r < 4; r++) send(CMD_SAMPLE, 3'd0, 4'(r), 4'd0, 32'sh0);
        // Partial sample: only the last element is refreshed.
        send(CMD_SAMPLE, 3'd0, 4'd3, 4'd0, 32'shFFFF_0000);
        send(CMD_MEAN, 3'd1, 4'd2, 4'd0, 32'sh0002_8000);
        send(CMD_SAMPLE, 3'd0, 4'd3, 4'd0, 32'sh0000_0001);

        run_phase(5'd1, 5'd8, 0, 60, 1'b0);
        run_phase(5'd16, 5'd1, 57, 60, 1'b1);
        run_phase(5'd0, 5'd15, 21, 40, 1'b0);
        run_phase(5'd31, 5'd0, 0, 40, 1'b0);
        run_phase(5'd2, 5'd3, 57, 60, 1'b0);
        run_phase(5'd5, 5'd4, 21, 60, 1'b1);
        run_phase(5'd3, 5'd6, 0, 60, 1'b0);
        run_phase(5'd8, 5'd2, 57, 50, 1'b0);
        run_phase(5'd4, 5'd1, 21, 50, 1'b0);

        while (sb.pending() > 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
